### hw/rtl/addt_pkg.sv
// Shared types, widths and constants for the angle-dependent dead-time block.
`default_nettype none

package addt_pkg;

  // Field and datapath widths.
  localparam int ANGLE_W = 16;
  localparam int VAL_W   = 24;
  localparam int DIST_W  = 15;
  localparam int TICK_W  = 16;
  localparam int CORR_W  = 8;
  localparam int IDX_W   = 3;
  localparam int SQ_W    = 2 * DIST_W;
  localparam int CUBE_W  = 3 * DIST_W;
  localparam int CUBE_LO_W = 20;
  localparam int CUBE_HI_W = CUBE_W - CUBE_LO_W;
  localparam int PROD_HI_W = CUBE_HI_W + VAL_W;
  localparam int PROD_LO_W = CUBE_LO_W + VAL_W;
  localparam int CUB_W     = PROD_HI_W - CUBE_LO_W;
  localparam int SUM_W     = CUB_W + 1;

  // Number of register stages from input to output register.
  localparam int STAGES = 8;

  // Default values for the top-level parameters.
  localparam int                TABLE_BITS_DEF  = 8;
  localparam logic [VAL_W-1:0]  FIXED_H2L_DEF   = 24'd3072;
  localparam logic [VAL_W-1:0]  FIXED_L2H_DEF   = 24'd3072;
  localparam logic [CORR_W-1:0] CORR_H2L_DEF    = 8'd0;
  localparam logic [CORR_W-1:0] CORR_L2H_DEF    = 8'd0;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_VARIABLE_MODE = 3'd0;
  localparam logic [IDX_W-1:0] REG_CURVE_BEGIN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_CURVE_FACTOR  = 3'd2;
  localparam logic [IDX_W-1:0] REG_CURVE_PLATEAU = 3'd3;
  localparam logic [IDX_W-1:0] REG_OUTSIDE_VALUE = 3'd4;
  localparam logic [IDX_W-1:0] REG_LOWER_LIMIT   = 3'd5;
  localparam logic [IDX_W-1:0] REG_UPPER_LIMIT   = 3'd6;
  localparam logic [IDX_W-1:0] REG_ZERO_WIDTH    = 3'd7;

  // Source of a lane's dead-time value.
  typedef enum logic [1:0] {
    SEL_CUBIC,
    SEL_PLATEAU,
    SEL_OUTSIDE,
    SEL_FIXED
  } sel_t;

  // Curve and limit settings shared by both lanes.
  typedef struct packed {
    logic [VAL_W-1:0] curve_begin;
    logic [VAL_W-1:0] curve_factor;
    logic [VAL_W-1:0] curve_plateau;
    logic [VAL_W-1:0] outside_value;
    logic [VAL_W-1:0] lower_limit;
    logic [VAL_W-1:0] upper_limit;
  } curve_cfg_t;

endpackage

`default_nettype wire

### hw/rtl/addt_lane.sv
// One dead-time lane: cubic curve, value selection, clamping and correction.
`default_nettype none

module addt_lane #(
  parameter logic [addt_pkg::VAL_W-1:0]  FIXED_VALUE = addt_pkg::FIXED_H2L_DEF,
  parameter logic [addt_pkg::CORR_W-1:0] CORRECTION  = addt_pkg::CORR_H2L_DEF
) (
  input  wire logic                             clk,
  input  wire logic [addt_pkg::STAGES-1:0]      load,
  input  wire addt_pkg::curve_cfg_t             cfg,
  input  wire addt_pkg::sel_t                   sel_in,
  input  wire logic [addt_pkg::DIST_W-1:0]      dist_in,
  output logic      [addt_pkg::TICK_W-1:0]      ticks
);

  localparam int VW = addt_pkg::VAL_W;
  localparam int CW = addt_pkg::CUB_W;
  localparam int LW = addt_pkg::CUBE_LO_W;
  localparam int SW = addt_pkg::SQ_W;
  localparam int QW = addt_pkg::CUBE_W;
  localparam int HW = addt_pkg::PROD_HI_W;
  localparam int PW = addt_pkg::PROD_LO_W;

  addt_pkg::sel_t sel1, sel2, sel3, sel4, sel5;
  logic [addt_pkg::DIST_W-1:0]    dist1, dist2;
  logic [addt_pkg::SQ_W-1:0]      sq2;
  logic [addt_pkg::CUBE_W-1:0]    cube3;
  logic [addt_pkg::PROD_HI_W-1:0] prod_hi4;
  logic [addt_pkg::PROD_LO_W-1:0] prod_lo4;
  logic [CW-1:0]                  cub5;
  logic [CW:0]                    val6;
  logic [VW-1:0]                  clamp7;

  logic [addt_pkg::PROD_HI_W:0]   part_sum;
  logic [CW:0]                    val_next;
  logic [VW-1:0]                  clamp_next;
  logic [addt_pkg::TICK_W:0]      tick_sum;

  // Region code and crossing distance.
  always_ff @(posedge clk) begin
    if (load[0]) begin
      sel1  <= sel_in;
      dist1 <= dist_in;
    end
  end

  // Distance squared.
  always_ff @(posedge clk) begin
    if (load[1]) begin
      sel2  <= sel1;
      dist2 <= dist1;
      sq2   <= SW'(dist1) * SW'(dist1);
    end
  end

  // Distance cubed.
  always_ff @(posedge clk) begin
    if (load[2]) begin
      sel3  <= sel2;
      cube3 <= QW'(sq2) * QW'(dist2);
    end
  end

  // Cube times gain, split into upper and lower partial products.
  always_ff @(posedge clk) begin
    if (load[3]) begin
      sel4     <= sel3;
      prod_hi4 <= HW'(cube3[addt_pkg::CUBE_W-1:LW]) * HW'(cfg.curve_factor);
      prod_lo4 <= PW'(cube3[LW-1:0]) * PW'(cfg.curve_factor);
    end
  end

  // Combine the partial products and drop the fraction.
  assign part_sum = {1'b0, prod_hi4}
                  + {{(addt_pkg::PROD_HI_W + 1 - (addt_pkg::PROD_LO_W - LW)){1'b0}},
                     prod_lo4[addt_pkg::PROD_LO_W-1:LW]};

  always_ff @(posedge clk) begin
    if (load[4]) begin
      sel5 <= sel4;
      cub5 <= part_sum[addt_pkg::PROD_HI_W-1:LW];
    end
  end

  // Pick the dead-time source.
  always_comb begin
    unique case (sel5)
      addt_pkg::SEL_CUBIC:   val_next = {{(CW + 1 - VW){1'b0}}, cfg.curve_begin} + {1'b0, cub5};
      addt_pkg::SEL_PLATEAU: val_next = {{(CW + 1 - VW){1'b0}}, cfg.curve_plateau};
      addt_pkg::SEL_OUTSIDE: val_next = {{(CW + 1 - VW){1'b0}}, cfg.outside_value};
      addt_pkg::SEL_FIXED:   val_next = {{(CW + 1 - VW){1'b0}}, FIXED_VALUE};
      default:               val_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load[5]) begin
      val6 <= val_next;
    end
  end

  // Clamp to the limits; the lower-limit test is made first.
  always_comb begin
    priority if (val6 < {{(CW + 1 - VW){1'b0}}, cfg.lower_limit}) begin
      clamp_next = cfg.lower_limit;
    end else if (val6 > {{(CW + 1 - VW){1'b0}}, cfg.upper_limit}) begin
      clamp_next = cfg.upper_limit;
    end else begin
      clamp_next = val6[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load[6]) begin
      clamp7 <= clamp_next;
    end
  end

  // Whole ticks plus driver correction, saturated.
  assign tick_sum = {1'b0, clamp7[VW-1:VW-addt_pkg::TICK_W]}
                  + {{(addt_pkg::TICK_W + 1 - addt_pkg::CORR_W){1'b0}}, CORRECTION};

  always_ff @(posedge clk) begin
    if (load[7]) begin
      ticks <= tick_sum[addt_pkg::TICK_W] ? '1 : tick_sum[addt_pkg::TICK_W-1:0];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/angle_dependent_deadtime.sv
// Top level of the angle-dependent bridge dead-time generator.
// Each accepted phase angle yields one pair of dead-times in whole ticks. A new angle can
// be taken in every cycle while in_stall is low. The pipeline has eight stages: region
// decode, square, cube, split gain multiply, partial-product merge, value select, clamp,
// and correction with saturation. Stalls on the output hold the finished pair while empty
// stages upstream keep filling. The user must write configuration through the plain write
// port only while no transaction is in flight; the block itself does not enforce this.
`default_nettype none

module angle_dependent_deadtime #(
  parameter int                           TABLE_BITS             = addt_pkg::TABLE_BITS_DEF,
  parameter logic [addt_pkg::VAL_W-1:0]  FIXED_HIGH_TO_LOW      = addt_pkg::FIXED_H2L_DEF,
  parameter logic [addt_pkg::VAL_W-1:0]  FIXED_LOW_TO_HIGH      = addt_pkg::FIXED_L2H_DEF,
  parameter logic [addt_pkg::CORR_W-1:0] CORRECTION_HIGH_TO_LOW = addt_pkg::CORR_H2L_DEF,
  parameter logic [addt_pkg::CORR_W-1:0] CORRECTION_LOW_TO_HIGH = addt_pkg::CORR_L2H_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [addt_pkg::ANGLE_W-1:0]  phase_angle,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [addt_pkg::TICK_W-1:0]   high_to_low_ticks,
  output logic      [addt_pkg::TICK_W-1:0]   low_to_high_ticks,
  input  wire logic                          cfg_write,
  input  wire logic [addt_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [addt_pkg::VAL_W-1:0]    cfg_data
);

  localparam int AW = addt_pkg::ANGLE_W;
  localparam int DW = addt_pkg::DIST_W;
  localparam int NS = addt_pkg::STAGES;
  localparam logic [AW-1:0] QMASK    = {AW{1'b1}} << (AW - TABLE_BITS);
  localparam logic [AW:0]   HALF     = 17'h08000;
  localparam logic [AW:0]   FULL     = 17'h10000;

  // Configuration registers.
  logic                      variable_mode;
  logic [DW-1:0]             zero_width;
  addt_pkg::curve_cfg_t      cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      variable_mode     <= 1'b0;
      zero_width        <= '0;
      cfg.curve_begin   <= '0;
      cfg.curve_factor  <= '0;
      cfg.curve_plateau <= '0;
      cfg.outside_value <= '0;
      cfg.lower_limit   <= '0;
      cfg.upper_limit   <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        addt_pkg::REG_VARIABLE_MODE: variable_mode     <= cfg_data[0];
        addt_pkg::REG_CURVE_BEGIN:   cfg.curve_begin   <= cfg_data;
        addt_pkg::REG_CURVE_FACTOR:  cfg.curve_factor  <= cfg_data;
        addt_pkg::REG_CURVE_PLATEAU: cfg.curve_plateau <= cfg_data;
        addt_pkg::REG_OUTSIDE_VALUE: cfg.outside_value <= cfg_data;
        addt_pkg::REG_LOWER_LIMIT:   cfg.lower_limit   <= cfg_data;
        addt_pkg::REG_UPPER_LIMIT:   cfg.upper_limit   <= cfg_data;
        addt_pkg::REG_ZERO_WIDTH:    zero_width        <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline occupancy; a stage loads when it is empty or its content moves on.
  logic [NS-1:0] valid;
  logic [NS:0]   ready;

  always_comb begin
    ready[NS] = !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      ready[k] = !valid[k] || ready[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (ready[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign in_stall  = !ready[0];
  assign out_valid = valid[NS-1];

  // Quantize the angle and find the region and crossing distance of each lane.
  logic [AW:0]     ang;
  logic [AW:0]     zw;
  logic [AW:0]     dist_h_lo, dist_h_hi, dist_l_hi;
  addt_pkg::sel_t  sel_h, sel_l;
  logic [DW-1:0]   dist_h, dist_l;

  assign ang       = {1'b0, phase_angle & QMASK};
  assign zw        = {{(AW + 1 - DW){1'b0}}, zero_width};
  assign dist_h_lo = ang - HALF;
  assign dist_h_hi = FULL - ang;
  assign dist_l_hi = HALF - ang;

  // High-to-low curve on the second half turn.
  always_comb begin
    dist_h = '0;
    if (!variable_mode) begin
      sel_h = addt_pkg::SEL_FIXED;
    end else if (ang > HALF) begin
      priority if (dist_h_lo < zw) begin
        sel_h  = addt_pkg::SEL_CUBIC;
        dist_h = dist_h_lo[DW-1:0];
      end else if (dist_h_hi < zw) begin
        sel_h  = addt_pkg::SEL_CUBIC;
        dist_h = dist_h_hi[DW-1:0];
      end else begin
        sel_h  = addt_pkg::SEL_PLATEAU;
      end
    end else begin
      sel_h = addt_pkg::SEL_OUTSIDE;
    end
  end

  // Low-to-high curve on the first half turn.
  always_comb begin
    dist_l = '0;
    if (!variable_mode) begin
      sel_l = addt_pkg::SEL_FIXED;
    end else if (ang < HALF) begin
      priority if (ang < zw) begin
        sel_l  = addt_pkg::SEL_CUBIC;
        dist_l = ang[DW-1:0];
      end else if (dist_l_hi < zw) begin
        sel_l  = addt_pkg::SEL_CUBIC;
        dist_l = dist_l_hi[DW-1:0];
      end else begin
        sel_l  = addt_pkg::SEL_PLATEAU;
      end
    end else begin
      sel_l = addt_pkg::SEL_OUTSIDE;
    end
  end

  // The two dead-time lanes.
  addt_lane #(
    .FIXED_VALUE (FIXED_HIGH_TO_LOW),
    .CORRECTION  (CORRECTION_HIGH_TO_LOW)
  ) u_lane_h2l (
    .clk     (clk),
    .load    (ready[NS-1:0]),
    .cfg     (cfg),
    .sel_in  (sel_h),
    .dist_in (dist_h),
    .ticks   (high_to_low_ticks)
  );

  addt_lane #(
    .FIXED_VALUE (FIXED_LOW_TO_HIGH),
    .CORRECTION  (CORRECTION_LOW_TO_HIGH)
  ) u_lane_l2h (
    .clk     (clk),
    .load    (ready[NS-1:0]),
    .cfg     (cfg),
    .sel_in  (sel_l),
    .dist_in (dist_l),
    .ticks   (low_to_high_ticks)
  );

endmodule

`default_nettype wire
